// File: rtl/rhh_pkg.sv
// Shared types and constants of the Robin Hood hash table.
`timescale 1ns / 1ps
package rhh_pkg;

  // Default table geometry.
  localparam int SLOTS_DEF      = 1024;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Configuration register reset value and width.
  localparam int          FILL_W       = 11;
  localparam logic [10:0] MAX_FILL_RST = 11'd768;

  // Configuration register byte addresses.
  localparam logic [1:0] ADDR_MAX_FILL = 2'd0;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_START,
    S_PROBE,
    S_SHIFT,
    S_CLEAR,
    S_DONE
  } state_e;

endpackage

// File: rtl/robin_hood_hash_table.sv
// Robin Hood hash table: open addressing, linear probing, backward-shift delete.
//
// Requests arrive as beats on the input channel (valid/stall) with a request
// type, key, caller-computed hash and value; each request yields one result beat
// (status, found value, entry count) on the output channel. One request is
// worked on at a time. All slots live in one synchronous memory that is read one
// slot per cycle, with the slot just examined written back in the same cycle.
// Steps per request: accept; reduce the hash when SLOTS is not a power of two
// (skipped otherwise); issue the home read; then probe slot after slot (insert,
// lookup); a remove adds a step per shifted entry and one more to empty the last
// slot of the run; then hand the result to the output register. A refused
// insert, or a lookup or remove on an empty table, goes from accept straight to
// the result. Clear sweeps every slot of the memory. After reset the same sweep
// runs with the input stalled; configuration writes are
// taken at any time. The result register lets a new request be accepted while
// the last result still waits; a stalled receiver only holds up a finished
// request until the register frees.
// max_fill is at APB byte address 0.
`timescale 1ns / 1ps
module robin_hood_hash_table #(
  parameter int SLOTS      = rhh_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = rhh_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] key_i,
  input  logic [31:0] key_hash_i,
  input  logic [31:0] value_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] found_value_o,
  output logic [10:0] entry_count_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rhh_pkg::*;

  localparam int IDXW = $clog2(SLOTS);
  localparam int PLW  = $clog2(SLOTS + 1);
  localparam int KW   = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int MW   = PLW + KW + VW;
  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(SLOTS - 1);
  localparam logic [PLW-1:0]  SLOTS_PL  = PLW'(SLOTS);
  localparam logic [31:0]     SLOTS_W   = 32'(SLOTS);
  localparam logic [31:0]     RECIP     = 32'((64'd1 << 32) / 64'(SLOTS));

  state_e state_q, state_d;
  req_e   req_q, req_d;

  logic [KW-1:0]      key_q, key_d;
  logic [VW-1:0]      val_q, val_d;
  logic [31:0]        hash_q, hash_d;
  logic [31:0]        quo_q, quo_d;
  logic [4:0]         bit_q, bit_d;
  logic [IDXW-1:0]    cur_q, cur_d, cur_nxt;
  logic [IDXW-1:0]    hole_q, hole_d;
  logic [PLW-1:0]     cd_q, cd_d;
  logic [PLW-1:0]     cnt_q, cnt_d;
  logic [FILL_W-1:0]  max_fill_q;
  logic [1:0]         res_status_q, res_status_d;
  logic [31:0]        res_found_q, res_found_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q, out_status_d;
  logic [31:0]        out_found_q, out_found_d;
  logic [10:0]        out_cnt_q, out_cnt_d;

  // Slot memory: {probe length, key, value}, probe length zero means empty.
  logic [MW-1:0]      slot_mem [SLOTS];
  logic [MW-1:0]      rd_q;
  logic [IDXW-1:0]    rd_addr;
  logic               mem_we;
  logic [IDXW-1:0]    mem_waddr;
  logic [MW-1:0]      mem_wdata;

  logic [PLW-1:0]     rd_plen;
  logic [KW-1:0]      rd_key;
  logic [VW-1:0]      rd_val;
  logic               in_acc;
  logic               out_free;
  logic               ins_full;
  logic [63:0]        quo_full;

  assign rd_plen  = rd_q[MW-1 -: PLW];
  assign rd_key   = rd_q[KW+VW-1 -: KW];
  assign rd_val   = rd_q[VW-1:0];
  assign cur_nxt  = (cur_q == LAST_SLOT) ? '0 : cur_q + IDXW'(1);
  assign rd_addr  = (state_q == S_START) ? cur_q : cur_nxt;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ins_full = (32'(cnt_q) >= 32'(max_fill_q)) || (cnt_q >= SLOTS_PL);

  // Quotient estimate of the hash by the slot count, at most one too small.
  assign quo_full = {32'd0, hash_q} * {32'd0, RECIP};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (cur_q == LAST_SLOT) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          priority if (req_e'(req_type_i) == REQ_CLEAR) begin
            state_d = S_CLEAR;
          end else if (req_e'(req_type_i) == REQ_INSERT && ins_full) begin
            state_d = S_DONE;
          end else if (req_e'(req_type_i) != REQ_INSERT && cnt_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = POW2 ? S_START : S_HASH;
          end
        end
      end
      S_HASH: begin
        if (bit_q == 5'd0) state_d = S_START;
      end
      S_START: state_d = S_PROBE;
      S_PROBE: begin
        if (req_q == REQ_INSERT) begin
          if (rd_plen == '0) state_d = S_DONE;
        end else begin
          priority if (rd_plen < cd_q) begin
            state_d = S_DONE;
          end else if (rd_key == key_q) begin
            state_d = (req_q == REQ_REMOVE) ? S_SHIFT : S_DONE;
          end else if (cd_q == SLOTS_PL) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_SHIFT: begin
        if (rd_plen <= PLW'(1)) state_d = S_DONE;
      end
      S_CLEAR: begin
        if (cur_q == LAST_SLOT) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    req_d        = req_q;
    key_d        = key_q;
    val_d        = val_q;
    hash_d       = hash_q;
    quo_d        = quo_q;
    bit_d        = bit_q;
    cur_d        = cur_q;
    hole_d       = hole_q;
    cd_d         = cd_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_q;
    mem_wdata    = {cd_q, key_q, val_q};
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_cnt_d    = out_cnt_q;

    unique case (state_q)
      S_INIT, S_CLEAR: begin
        // Sweep every slot to empty.
        mem_we    = 1'b1;
        mem_wdata = '0;
        cur_d     = cur_nxt;
      end
      S_IDLE: begin
        if (in_acc) begin
          req_d        = req_e'(req_type_i);
          key_d        = key_i[KW-1:0];
          val_d        = value_i[VW-1:0];
          hash_d       = key_hash_i;
          bit_d        = 5'd2;
          cd_d         = PLW'(1);
          res_found_d  = '0;
          res_status_d = ST_OK;
          cur_d        = POW2 ? key_hash_i[IDXW-1:0] : '0;
          priority if (req_e'(req_type_i) == REQ_CLEAR) begin
            cur_d = '0;
            cnt_d = '0;
          end else if (req_e'(req_type_i) == REQ_INSERT && ins_full) begin
            res_status_d = ST_FULL;
          end else if (req_e'(req_type_i) != REQ_INSERT && cnt_q == '0) begin
            res_status_d = ST_MISS;
          end else begin
            res_status_d = ST_OK;
          end
        end
      end
      S_HASH: begin
        // Remainder by reciprocal multiplication: estimate, subtract, correct.
        bit_d = bit_q - 5'd1;
        unique case (bit_q)
          5'd2: quo_d = quo_full[63:32];
          5'd1: hash_d = hash_q - 32'(quo_q * SLOTS_W);
          default: begin
            cur_d = (hash_q >= SLOTS_W) ? IDXW'(hash_q - SLOTS_W) : IDXW'(hash_q);
          end
        endcase
      end
      S_START: begin
        // Home read is issued this cycle.
      end
      S_PROBE: begin
        cur_d = cur_nxt;
        if (req_q == REQ_INSERT) begin
          if (rd_plen == '0) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + PLW'(1);
          end else if (cd_q > rd_plen) begin
            // Richer resident gives up its slot to the carried entry.
            mem_we = 1'b1;
            key_d  = rd_key;
            val_d  = rd_val;
            cd_d   = rd_plen + PLW'(1);
          end else begin
            cd_d = cd_q + PLW'(1);
          end
        end else begin
          priority if (rd_plen < cd_q) begin
            res_status_d = ST_MISS;
          end else if (rd_key == key_q) begin
            if (req_q == REQ_REMOVE) begin
              cnt_d  = cnt_q - PLW'(1);
              hole_d = cur_q;
            end else begin
              res_found_d = 32'(rd_val);
            end
          end else if (cd_q == SLOTS_PL) begin
            res_status_d = ST_MISS;
          end else begin
            cd_d = cd_q + PLW'(1);
          end
        end
      end
      S_SHIFT: begin
        // Pull the next displaced entry one slot back.
        mem_we    = 1'b1;
        mem_waddr = hole_q;
        cur_d     = cur_nxt;
        if (rd_plen > PLW'(1)) begin
          mem_wdata = {rd_plen - PLW'(1), rd_key, rd_val};
          hole_d    = cur_q;
        end else begin
          mem_wdata = {{PLW{1'b0}}, rd_key, rd_val};
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_cnt_d    = 11'(cnt_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      max_fill_q  <= MAX_FILL_RST;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && pready) begin
        max_fill_q <= pwdata[FILL_W-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    val_q        <= val_d;
    hash_q       <= hash_d;
    quo_q        <= quo_d;
    bit_q        <= bit_d;
    hole_q       <= hole_d;
    cd_q         <= cd_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_cnt_q    <= out_cnt_d;
  end

  // Slot memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= slot_mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_found_q;
  assign entry_count_o = out_cnt_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr == ADDR_MAX_FILL) ? 32'(max_fill_q) : '0;

  // The count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOTS_PL)
    else $error("entry count above table size");

  // A write during probing never hits the slot being read.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == S_PROBE || state_q == S_SHIFT)) |-> mem_waddr != rd_addr)
    else $error("slot written and read in the same cycle");

  // An insert only grows the count up to the fill limit.
  a_fill_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && cnt_d > cnt_q) |-> 32'(cnt_d) <= 32'(max_fill_q))
    else $error("insert went past the fill limit");

  // The result register is loaded only when it is free.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> state_q == S_DONE)
    else $error("result left while the output was stalled");

endmodule
